>>> rtl/ffha_pkg.sv
package ffha_pkg;

   localparam int HEAP_BYTES_DEF = 4096;
   localparam int IW = 15;
   localparam int SW = 14;
   localparam int NW = 17;
   localparam int HW = 12;
   localparam int TWO_BYTE_MIN = 64;
   localparam int ONE_BYTE_MAX = 63;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NULL    = 3'd1,
      ST_OOM     = 3'd2,
      ST_DOUBLE  = 3'd3,
      ST_INVALID = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD0,
      S_RD0W,
      S_RD1,
      S_EVAL,
      S_WLO,
      S_WHI,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      POST_WALK,
      POST_CHUNK2,
      POST_DONE
   } post_type;

   typedef struct packed {
      logic          we;
      logic [IW-1:0] waddr;
      logic [7:0]    wdata;
      logic [IW-1:0] raddr;
   } mem_req_type;

   function automatic logic hdr_two(input logic [SW-1:0] size);
      hdr_two = (size >= SW'(TWO_BYTE_MIN));
   endfunction

   function automatic logic [15:0] hdr_word(input logic [SW-1:0] size, input logic used);
      hdr_word = {size, hdr_two(size), used};
   endfunction

endpackage

>>> rtl/first_fit_heap_allocator.sv
// first-fit heap allocator over a byte heap with implicit chunk headers
// request channel (req_valid/req_ready): req_command 0 allocates req_bytes
// payload bytes, 1 frees the payload at req_handle
// response channel (rsp_valid/rsp_ready): one response per request with
// rsp_status and rsp_payload_offset (non-zero only for a good allocate)
// each non-null request walks the chunk headers from offset 0 through the
// single heap ram; every header visited is read with one ram read per header
// byte and then evaluated, and each header rewrite writes its low byte and,
// for a two-byte header, its high byte; rsp_valid is registered and rises
// after the walk and its rewrites have ended; one request is in flight at a
// time, and a new request is taken once the walk has finished and its
// response is parked in the output register
// after reset a clearing pass writes zero to every heap byte, during which
// req_ready stays low
// a stalled response only holds the block once the next walk is complete
module first_fit_heap_allocator import ffha_pkg::*; #(
   parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_command,
   input  logic [15:0]   req_bytes,
   input  logic [HW-1:0] req_handle,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    rsp_status,
   output logic [HW-1:0] rsp_payload_offset
);

   localparam int AW = $clog2(HEAP_BYTES);
   localparam logic [IW-1:0] LIMIT = IW'(HEAP_BYTES);
   localparam logic [AW-1:0] LAST  = AW'(HEAP_BYTES - 1);

   state_type      state_ff, state_in;
   post_type       post_ff, post_in;
   status_type     status_ff, status_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [IW-1:0]  i_ff, i_in, prev_ff, prev_in, wa_ff, wa_in, c2addr_ff, c2addr_in;
   logic [SW-1:0]  psize_ff, psize_in, c2size_ff, c2size_in;
   logic           have_prev_ff, have_prev_in, removed_ff, removed_in;
   logic           cmd_ff, cmd_in, wtwo_ff, wtwo_in;
   logic [NW-1:0]  need_ff, need_in;
   logic [HW-1:0]  handle_ff, handle_in, off_ff, off_in;
   logic [7:0]     b0_ff, b0_in, b1_ff, b1_in;
   logic [15:0]    wv_ff, wv_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [HW-1:0]  rsp_off_ff, rsp_off_in;

   mem_req_type    mreq;
   logic [7:0]     rdata;

   ffha_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
      .clock (clock),
      .mreq  (mreq),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      post_ff       <= post_in;
      status_ff     <= status_in;
      i_ff          <= i_in;
      prev_ff       <= prev_in;
      wa_ff         <= wa_in;
      c2addr_ff     <= c2addr_in;
      psize_ff      <= psize_in;
      c2size_ff     <= c2size_in;
      have_prev_ff  <= have_prev_in;
      removed_ff    <= removed_in;
      cmd_ff        <= cmd_in;
      wtwo_ff       <= wtwo_in;
      need_ff       <= need_in;
      handle_ff     <= handle_in;
      off_ff        <= off_in;
      b0_ff         <= b0_in;
      b1_ff         <= b1_in;
      wv_ff         <= wv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
   end

   always_comb begin
      logic [SW-1:0] sz;
      logic [IW-1:0] pay;
      logic [IW-1:0] nxt;
      logic [NW:0]   end_need;
      logic [NW-1:0] n1;
      logic [SW-1:0] merged;
      logic [IW-1:0] hi_addr;
      state_in      = state_ff;
      post_in       = post_ff;
      status_in     = status_ff;
      clr_in        = clr_ff;
      i_in          = i_ff;
      prev_in       = prev_ff;
      wa_in         = wa_ff;
      c2addr_in     = c2addr_ff;
      psize_in      = psize_ff;
      c2size_in     = c2size_ff;
      have_prev_in  = have_prev_ff;
      removed_in    = removed_ff;
      cmd_in        = cmd_ff;
      wtwo_in       = wtwo_ff;
      need_in       = need_ff;
      handle_in     = handle_ff;
      off_in        = off_ff;
      b0_in         = b0_ff;
      b1_in         = b1_ff;
      wv_in         = wv_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      mreq.we       = 1'b0;
      mreq.waddr    = i_ff;
      mreq.wdata    = '0;
      mreq.raddr    = i_ff;
      req_ready     = 1'b0;

      sz       = b0_ff[1] ? {b1_ff, b0_ff[7:2]} : {6'd0, b0_ff[7:2]};
      pay      = i_ff + (b0_ff[1] ? IW'(2) : IW'(1));
      nxt      = i_ff + IW'(sz);
      end_need = {{(NW+1-IW){1'b0}}, i_ff} + {1'b0, need_ff};
      n1       = {1'b0, req_bytes} + NW'(1);
      merged   = psize_ff + sz;
      hi_addr  = wa_ff + IW'(1);

      unique case (state_ff)
         S_CLEAR: begin
            mreq.we    = 1'b1;
            mreq.waddr = IW'(clr_ff);
            mreq.wdata = '0;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in       = req_command;
               need_in      = n1 + ((n1 > NW'(ONE_BYTE_MAX)) ? NW'(1) : NW'(0));
               handle_in    = req_handle;
               off_in       = '0;
               i_in         = '0;
               have_prev_in = 1'b0;
               removed_in   = 1'b0;
               if ((!req_command && req_bytes == '0) || (req_command && req_handle == '0)) begin
                  status_in = ST_NULL;
                  state_in  = S_DONE;
               end else begin
                  status_in = ST_OK;
                  state_in  = S_RD0;
               end
            end
         end
         S_RD0: begin
            if (i_ff >= LIMIT) begin
               if (!cmd_ff) begin
                  status_in = ST_OOM;
               end else begin
                  status_in = removed_ff ? ST_OK : ST_INVALID;
               end
               state_in = S_DONE;
            end else begin
               mreq.raddr = i_ff;
               state_in   = S_RD0W;
            end
         end
         S_RD0W: begin
            b0_in = rdata;
            b1_in = '0;
            if (rdata[1] && (i_ff + IW'(1)) < LIMIT) begin
               mreq.raddr = i_ff + IW'(1);
               state_in   = S_RD1;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_RD1: begin
            b1_in    = rdata;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!cmd_ff) begin
               if (!b0_ff[0]) begin
                  if (sz == '0 || {{(NW-SW){1'b0}}, sz} >= need_ff) begin
                     if (sz == '0 && end_need > (NW+1)'(HEAP_BYTES)) begin
                        status_in = ST_OOM;
                        state_in  = S_DONE;
                     end else begin
                        wa_in     = i_ff;
                        wv_in     = hdr_word(SW'(need_ff), 1'b1);
                        wtwo_in   = hdr_two(SW'(need_ff));
                        c2addr_in = IW'(end_need);
                        off_in    = HW'(i_ff + (hdr_two(SW'(need_ff)) ? IW'(2) : IW'(1)));
                        status_in = ST_OK;
                        if (sz == '0) begin
                           c2size_in = '0;
                           post_in   = (end_need < (NW+1)'(HEAP_BYTES)) ? POST_CHUNK2 : POST_DONE;
                        end else begin
                           c2size_in = sz - SW'(need_ff);
                           post_in   = ({{(NW-SW){1'b0}}, sz} > need_ff) ? POST_CHUNK2 : POST_DONE;
                        end
                        state_in = S_WLO;
                     end
                  end else begin
                     i_in     = nxt;
                     state_in = S_RD0;
                  end
               end else if (sz == '0) begin
                  status_in = ST_OOM;
                  state_in  = S_DONE;
               end else begin
                  i_in     = nxt;
                  state_in = S_RD0;
               end
            end else begin
               if (!b0_ff[0]) begin
                  if (sz == '0) begin
                     status_in = removed_ff ? ST_OK : ST_INVALID;
                     if (have_prev_ff) begin
                        wa_in    = prev_ff;
                        wv_in    = hdr_word('0, 1'b0);
                        wtwo_in  = 1'b0;
                        post_in  = POST_DONE;
                        state_in = S_WLO;
                     end else begin
                        state_in = S_DONE;
                     end
                  end else if (pay == IW'(handle_ff) && !removed_ff) begin
                     status_in = ST_DOUBLE;
                     state_in  = S_DONE;
                  end else if (have_prev_ff) begin
                     psize_in = merged;
                     wa_in    = prev_ff;
                     wv_in    = hdr_word(merged, 1'b0);
                     wtwo_in  = hdr_two(merged);
                     post_in  = POST_WALK;
                     i_in     = nxt;
                     state_in = S_WLO;
                  end else begin
                     prev_in      = i_ff;
                     psize_in     = sz;
                     have_prev_in = 1'b1;
                     i_in         = nxt;
                     state_in     = S_RD0;
                  end
               end else if (sz == '0) begin
                  status_in = removed_ff ? ST_OK : ST_INVALID;
                  state_in  = S_DONE;
               end else if (pay == IW'(handle_ff)) begin
                  wa_in      = i_ff;
                  wv_in      = hdr_word(sz, 1'b0);
                  wtwo_in    = hdr_two(sz);
                  removed_in = 1'b1;
                  post_in    = POST_WALK;
                  state_in   = S_WLO;
               end else begin
                  have_prev_in = 1'b0;
                  i_in         = nxt;
                  state_in     = S_RD0;
               end
            end
         end
         S_WLO, S_WHI: begin
            if (state_ff == S_WLO) begin
               mreq.we    = (wa_ff < LIMIT);
               mreq.waddr = wa_ff;
               mreq.wdata = wv_ff[7:0];
            end else begin
               mreq.we    = (hi_addr < LIMIT);
               mreq.waddr = hi_addr;
               mreq.wdata = wv_ff[15:8];
            end
            if (state_ff == S_WLO && wtwo_ff) begin
               state_in = S_WHI;
            end else begin
               case (post_ff)
                  POST_WALK: state_in = S_RD0;
                  POST_CHUNK2: begin
                     wa_in    = c2addr_ff;
                     wv_in    = hdr_word(c2size_ff, 1'b0);
                     wtwo_in  = hdr_two(c2size_ff);
                     post_in  = POST_DONE;
                     state_in = S_WLO;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_off_in    = off_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_off_ff;

endmodule

>>> rtl/ffha_mem.sv
module ffha_mem import ffha_pkg::*; #(
   parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
   input  logic        clock,
   input  mem_req_type mreq,
   output logic [7:0]  rdata
);

   localparam int AW = $clog2(HEAP_BYTES);

   logic [7:0] mem [HEAP_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mreq.we) begin
         mem[mreq.waddr[AW-1:0]] <= mreq.wdata;
      end
      rdata_ff <= mem[mreq.raddr[AW-1:0]];
   end

   assign rdata = rdata_ff;

endmodule

>>> tb/first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb import ffha_pkg::*;;

   localparam int HEAP = 4096;
   localparam bit CMD_ALLOC = 1'b0;
   localparam bit CMD_FREE = 1'b1;

   // predictor of the chunk list plus the queue of expected responses
   class heap_scoreboard;
      byte unsigned heap_img[HEAP];
      logic [2:0] exp_status[$];
      logic [HW-1:0] exp_offset[$];
      int errors;
      logic [HW-1:0] live[$];

      function new();
         foreach (heap_img[k]) heap_img[k] = 0;
         errors = 0;
      endfunction

      function int rd(int a);
         return (a < HEAP) ? heap_img[a] : 0;
      endfunction

      function void wr(int a, int v);
         if (a < HEAP) heap_img[a] = v[7:0];
      endfunction

      function int hlen(int a);
         return 1 + ((rd(a) >> 1) & 1);
      endfunction

      function int csize(int a);
         int b;
         b = rd(a);
         if ((b & 2) == 0) return b >> 2;
         return ((b | (rd(a + 1) << 8)) & 16'hffff) >> 2;
      endfunction

      function void set_chunk(int a, int used, int sz);
         int v;
         sz = sz & 14'h3fff;
         if (sz < TWO_BYTE_MIN) wr(a, (sz << 2) | used);
         else begin
            v = (sz << 2) | used | 2;
            wr(a, v);
            wr(a + 1, v >> 8);
         end
      endfunction

      function void predict_alloc(int req, output logic [2:0] st, output logic [HW-1:0] off);
         int need, i, sz;
         st = ST_OK;
         off = 0;
         if (req == 0) begin
            st = ST_NULL;
            return;
         end
         need = req + 1;
         if (need > ONE_BYTE_MAX) need++;
         i = 0;
         while (i < HEAP) begin
            sz = csize(i);
            if ((rd(i) & 1) == 0) begin
               if (sz == 0) begin
                  if (i + need > HEAP) break;
                  set_chunk(i, 1, need);
                  if (i + need < HEAP) set_chunk(i + need, 0, 0);
                  off = HW'(i + hlen(i));
                  return;
               end
               if (need <= sz) begin
                  set_chunk(i, 1, need);
                  if (sz > need) set_chunk(i + need, 0, sz - need);
                  off = HW'(i + hlen(i));
                  return;
               end
            end else if (sz == 0) break;
            i += sz;
         end
         st = ST_OOM;
      endfunction

      function void predict_free(int h, output logic [2:0] st);
         int i, prv, sz, pay;
         bit have_prv, removed;
         i = 0;
         prv = 0;
         have_prv = 0;
         removed = 0;
         st = ST_OK;
         if (h == 0) begin
            st = ST_NULL;
            return;
         end
         while (i < HEAP) begin
            sz = csize(i);
            pay = i + hlen(i);
            if ((rd(i) & 1) == 0) begin
               if (sz == 0) begin
                  if (have_prv) set_chunk(prv, 0, 0);
                  break;
               end
               if (pay == h && !removed) begin
                  st = ST_DOUBLE;
                  return;
               end
               if (have_prv) set_chunk(prv, 0, csize(prv) + sz);
               else begin
                  prv = i;
                  have_prv = 1;
               end
               i += sz;
            end else begin
               if (sz == 0) break;
               if (pay == h) begin
                  set_chunk(i, 0, sz);
                  removed = 1;
               end else begin
                  have_prv = 0;
                  i += sz;
               end
            end
         end
         if (!removed) st = ST_INVALID;
      endfunction

      function void note_request(bit cmd, int nbytes, int h);
         logic [2:0] st;
         logic [HW-1:0] off;
         off = 0;
         if (cmd == CMD_ALLOC) predict_alloc(nbytes, st, off);
         else predict_free(h, st);
         if (cmd == CMD_ALLOC && st == ST_OK) live.push_back(off);
         exp_status.push_back(st);
         exp_offset.push_back(off);
      endfunction

      function void check_response(logic [2:0] st, logic [HW-1:0] off);
         logic [2:0] es;
         logic [HW-1:0] eo;
         if (exp_status.size() == 0) begin
            $display("%0t unexpected response status %0d offset %0d", $time, st, off);
            errors++;
            return;
         end
         es = exp_status.pop_front();
         eo = exp_offset.pop_front();
         if (st !== es) begin
            $display("%0t status mismatch expected %0d actual %0d", $time, es, st);
            errors++;
         end
         if (off !== eo) begin
            $display("%0t offset mismatch expected %0d actual %0d", $time, eo, off);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic req_command = 0;
   logic [15:0] req_bytes = 0;
   logic [HW-1:0] req_handle = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [2:0] rsp_status;
   logic [HW-1:0] rsp_payload_offset;

   heap_scoreboard sb;
   int idle_pct = 11;
   bit hold_rsp = 0;
   bit stim_done = 0;

   first_fit_heap_allocator DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #500ms;
      $display("status: fail");
      $finish;
   end

   task automatic send(bit cmd, int nbytes, int h);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_bytes <= nbytes[15:0];
      req_handle <= h[HW-1:0];
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, nbytes, h);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.exp_status.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_handle();
      int k;
      if (sb.live.size() == 0 || $urandom_range(9) == 0) return $urandom_range(4095);
      k = $urandom_range(sb.live.size() - 1);
      pick_handle = sb.live[k];
      if ($urandom_range(3) != 0) sb.live.delete(k);
   endfunction

   function automatic int pick_size();
      case ($urandom_range(9))
         0: return $urandom_range(65535);
         1: return $urandom_range(60, 70);
         2: return $urandom_range(200, 900);
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp_status, rsp_payload_offset);
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= idle_pct);
   end

   initial begin
      int n;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 0;
      send(CMD_ALLOC, 0, 0);
      send(CMD_FREE, 0, 0);
      send(CMD_FREE, 4095, 4095);
      send(CMD_ALLOC, 65535, 0);
      send(CMD_ALLOC, 62, 0);
      send(CMD_ALLOC, 63, 0);
      send(CMD_ALLOC, 1, 0);
      send(CMD_FREE, 0, 1);
      send(CMD_FREE, 0, 65);
      send(CMD_FREE, 0, 65);
      send(CMD_FREE, 0, 2);
      send(CMD_ALLOC, 10, 0);
      send(CMD_FREE, 0, 3);
      send(CMD_FREE, 0, 130);
      send(CMD_ALLOC, 4094, 0);
      send(CMD_ALLOC, 4093, 0);
      send(CMD_FREE, 0, 2);
      send(CMD_ALLOC, 4094, 0);
      send(CMD_FREE, 0, 2);
      drain();
      sb.live.delete();
      // random allocate and free traffic
      for (n = 0; n < 1450; n++) begin
         if (n == 300) idle_pct = 0;
         if (n == 500) idle_pct = 11;
         if (n == 700) begin
            drain();
         end
         if (n == 900) fork
            begin
               hold_rsp = 1;
               repeat (400) @(posedge clock);
               hold_rsp = 0;
            end
         join_none
         if ($urandom_range(1)) send(CMD_ALLOC, pick_size(), $urandom_range(4095));
         else send(CMD_FREE, $urandom_range(65535), pick_handle());
      end
      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.exp_status.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

>>> files.f
rtl/ffha_pkg.sv
rtl/ffha_mem.sv
rtl/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_tb.sv
